// ===== sv/batd_pkg.sv =====
// ----------------------------------------------------------------------------
// batd_pkg: shared types for the bus action trace decoder
// Result codes and the result record passed from the parser to the top level.
// ----------------------------------------------------------------------------
package batd_pkg;

  // What a result item describes.
  typedef enum logic [3:0] {
    KIND_RD32     = 4'd0,
    KIND_RD64     = 4'd1,
    KIND_WR32     = 4'd2,
    KIND_WR64     = 4'd3,
    KIND_RDIGN32  = 4'd4,
    KIND_RDIGN64  = 4'd5,
    KIND_POLL32   = 4'd6,
    KIND_POLL64   = 4'd7,
    KIND_BUF_DONE = 4'd8
  } kind_e;

  // Buffer status reported with the buffer-done item.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_COMPRESSED  = 3'd4,
    ST_LEN_SMALL   = 3'd5,
    ST_UNKNOWN_TAG = 3'd6,
    ST_TRUNCATED   = 3'd7
  } status_e;

  typedef struct packed {
    logic [31:0] trailer_crc;
    status_e     status;
    logic [63:0] data_mask;
    logic [63:0] data_value;
    logic [63:0] bus_addr;
    logic [31:0] bus_id;
    kind_e       kind;
  } batd_result_t;

endpackage

// ===== sv/bus_action_trace_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bus_action_trace_decoder_unit: replay trace to bus action decoder
// Streams a replay buffer byte by byte and emits bus action items.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per item and accepts a new item in every
// clock cycle unless backpressure holds a byte in the input register. An
// accepted byte is held in the input register and parsed from there by short
// logic (one 64-bit address add and the 33-bit end-of-buffer compare set the
// path). Its result, if any, is captured in the output register when that
// register advances. The buffer length is sampled with the first byte of each
// buffer. A checked 9-byte header opens the buffer; each later record
// completes on its last payload byte (on its tag byte if it has none) and a
// read, write, poll or ignore-read record yields one action item. The last
// byte of every buffer yields one buffer-done item with the status and the
// END record's CRC word, after which all state returns to its reset values.
// The output register advances whenever the output slot is empty or being
// taken, and the input register also loads whenever it is empty, so
// backpressure on the master side holds at most one byte in flight per stage.
// ----------------------------------------------------------------------------
module bus_action_trace_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] data_byte, [39:8] buffer_length
  input  logic [39:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] bus_id, [95:32] bus_addr, [159:96] data_value, [223:160] data_mask,
  // [226:224] status, [258:227] trailer_crc, [263:259] zero
  output logic [263:0] m_axis_tdata_o,
  // [3:0] kind
  output logic [3:0]   m_axis_tuser_o
);
  import batd_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic [31:0]  in_len_q;
  logic         advance;
  logic         res_valid;
  batd_result_t res;
  logic         out_valid_q;
  batd_result_t out_q;

  // The output register moves when the output slot can take a new value; the input register also loads while empty.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_len_q  <= s_axis_tdata_i[39:8];
    end
  end

  batd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_valid_q && advance),
    .data_byte_i     (in_byte_q),
    .buffer_length_i (in_len_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'd0, out_q.trailer_crc, out_q.status, out_q.data_mask,
                            out_q.data_value, out_q.bus_addr, out_q.bus_id};

endmodule

// ===== sv/batd_parser.sv =====
// ----------------------------------------------------------------------------
// batd_parser: per-byte trace parser
// Holds the decoder state and turns one buffer byte into at most one result.
// ----------------------------------------------------------------------------
module batd_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic [31:0]           buffer_length_i,
  output logic                  res_valid_o,
  output batd_pkg::batd_result_t res_o
);
  import batd_pkg::*;

  localparam logic [7:0]  TAG_START    = 8'd2;
  localparam logic [7:0]  TAG_END      = 8'd1;
  localparam logic [7:0]  TAG_ID       = 8'd9;
  localparam logic [7:0]  TAG_ADDR     = 8'd18;
  localparam logic [7:0]  TAG_MASK32   = 8'd169;
  localparam logic [7:0]  TAG_MASK64   = 8'd178;
  localparam logic [7:0]  TAG_RD32     = 8'd25;
  localparam logic [7:0]  TAG_RD32_INC = 8'd57;
  localparam logic [7:0]  TAG_RD64     = 8'd34;
  localparam logic [7:0]  TAG_RD64_INC = 8'd66;
  localparam logic [7:0]  TAG_POLL32   = 8'd153;
  localparam logic [7:0]  TAG_POLL64   = 8'd162;
  localparam logic [7:0]  TAG_IGN32    = 8'd121;
  localparam logic [7:0]  TAG_IGN32_INC = 8'd137;
  localparam logic [7:0]  TAG_IGN64    = 8'd130;
  localparam logic [7:0]  TAG_IGN64_INC = 8'd146;
  localparam logic [7:0]  TAG_WR32     = 8'd41;
  localparam logic [7:0]  TAG_WR32_INC = 8'd73;
  localparam logic [7:0]  TAG_Z32      = 8'd88;
  localparam logic [7:0]  TAG_Z32_INC  = 8'd104;
  localparam logic [7:0]  TAG_WR64     = 8'd50;
  localparam logic [7:0]  TAG_WR64_INC = 8'd82;
  localparam logic [7:0]  TAG_Z64      = 8'd96;
  localparam logic [7:0]  TAG_Z64_INC  = 8'd112;

  localparam logic [31:0] MAGIC_PLAIN  = 32'h0066424e;
  localparam logic [31:0] MAGIC_PACKED = 32'h007a424e;
  localparam logic [32:0] MIN_BUFFER   = 33'd14;
  localparam logic [31:0] POS_MAGIC    = 32'd4;
  localparam logic [31:0] POS_LENGTH   = 32'd8;

  typedef enum logic [2:0] {
    MODE_HEADER  = 3'd0,
    MODE_TAG     = 3'd1,
    MODE_PAYLOAD = 3'd2,
    MODE_TRAIL   = 3'd3,
    MODE_SKIP    = 3'd4
  } mode_e;

  typedef struct packed {
    logic       known;
    logic       is_action;
    kind_e      kind;
    logic [3:0] incr;
    logic       wide;
    logic       zero_val;
  } rec_info_t;

  function automatic rec_info_t rec_decode(input logic [7:0] tag);
    rec_info_t r;
    r = '{known: 1'b1, is_action: 1'b1, kind: KIND_RD32, incr: 4'd0,
          wide: 1'b0, zero_val: 1'b0};
    unique case (tag)
      TAG_END, TAG_ID, TAG_ADDR, TAG_MASK32, TAG_MASK64: r.is_action = 1'b0;
      TAG_RD32:      r.kind = KIND_RD32;
      TAG_RD32_INC:  begin r.kind = KIND_RD32; r.incr = 4'd4; end
      TAG_RD64:      begin r.kind = KIND_RD64; r.wide = 1'b1; end
      TAG_RD64_INC:  begin r.kind = KIND_RD64; r.wide = 1'b1; r.incr = 4'd8; end
      TAG_POLL32:    r.kind = KIND_POLL32;
      TAG_POLL64:    begin r.kind = KIND_POLL64; r.wide = 1'b1; end
      TAG_IGN32:     r.kind = KIND_RDIGN32;
      TAG_IGN32_INC: begin r.kind = KIND_RDIGN32; r.incr = 4'd4; end
      TAG_IGN64:     begin r.kind = KIND_RDIGN64; r.wide = 1'b1; end
      TAG_IGN64_INC: begin r.kind = KIND_RDIGN64; r.wide = 1'b1; r.incr = 4'd8; end
      TAG_WR32:      r.kind = KIND_WR32;
      TAG_WR32_INC:  begin r.kind = KIND_WR32; r.incr = 4'd4; end
      TAG_Z32:       begin r.kind = KIND_WR32; r.zero_val = 1'b1; end
      TAG_Z32_INC:   begin r.kind = KIND_WR32; r.zero_val = 1'b1; r.incr = 4'd4; end
      TAG_WR64:      begin r.kind = KIND_WR64; r.wide = 1'b1; end
      TAG_WR64_INC:  begin r.kind = KIND_WR64; r.wide = 1'b1; r.incr = 4'd8; end
      TAG_Z64:       begin r.kind = KIND_WR64; r.wide = 1'b1; r.zero_val = 1'b1; end
      TAG_Z64_INC:   begin
        r.kind = KIND_WR64; r.wide = 1'b1; r.zero_val = 1'b1; r.incr = 4'd8;
      end
      default: begin r.known = 1'b0; r.is_action = 1'b0; end
    endcase
    return r;
  endfunction

  logic [31:0] pos_q, pos_d, len_q, len_d, id_q, id_d, nmask_q, nmask_d;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  tag_q, tag_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] shift_q, shift_d, addr_q, addr_d, wmask_q, wmask_d;
  mode_e       mode_q, mode_d;
  status_e     err_q, err_d;

  logic [31:0] len_cur;
  logic [63:0] shifted, fin_shift, val;
  logic [7:0]  fin_tag;
  logic        fin, act, done;
  rec_info_t   info, fin_info;

  always_comb begin
    pos_d = pos_q; id_d = id_q; nmask_d = nmask_q; crc_d = crc_q;
    tag_d = tag_q; left_d = left_q; shift_d = shift_q; addr_d = addr_q;
    wmask_d = wmask_q; mode_d = mode_q; err_d = err_q;
    fin = 1'b0; fin_tag = tag_q; fin_shift = shift_q; act = 1'b0;
    res_o = '0;

    // The buffer length is taken from the first byte of each buffer.
    len_cur = (pos_q == '0) ? buffer_length_i : len_q;
    len_d   = len_cur;
    shifted = {data_byte_i, shift_q[63:8]};
    info    = rec_decode(data_byte_i);

    unique case (mode_q)
      MODE_HEADER: begin
        if (pos_q == '0) begin
          if ({1'b0, len_cur} < MIN_BUFFER) begin
            err_d = ST_TOO_SHORT; mode_d = MODE_SKIP;
          end else if (data_byte_i != TAG_START) begin
            err_d = ST_BAD_START; mode_d = MODE_SKIP;
          end
          shift_d = '0;
        end else begin
          shift_d = shifted;
          if (pos_q == POS_MAGIC) begin
            if (shifted[63:32] == MAGIC_PACKED) begin
              err_d = ST_COMPRESSED; mode_d = MODE_SKIP;
            end else if (shifted[63:32] != MAGIC_PLAIN) begin
              err_d = ST_BAD_MAGIC; mode_d = MODE_SKIP;
            end
            shift_d = '0;
          end else if (pos_q == POS_LENGTH) begin
            if (shifted[63:32] < len_cur) begin
              err_d = ST_LEN_SMALL; mode_d = MODE_SKIP;
            end else begin
              mode_d = MODE_TAG;
            end
            shift_d = '0;
          end
        end
      end
      MODE_TAG: begin
        if (!info.known) begin
          err_d = ST_UNKNOWN_TAG; mode_d = MODE_SKIP;
        end else begin
          tag_d   = data_byte_i;
          shift_d = '0;
          // Known tags never set bit 2 of the length field, so this fits.
          left_d  = {data_byte_i[1:0], 2'b00};
          if (data_byte_i[2:0] == 3'd0) begin
            fin = 1'b1; fin_tag = data_byte_i; fin_shift = '0;
          end else begin
            mode_d = MODE_PAYLOAD;
          end
        end
      end
      MODE_PAYLOAD: begin
        shift_d = shifted;
        left_d  = left_q - 4'd1;
        if (left_d == 4'd0) begin
          fin = 1'b1; fin_tag = tag_q; fin_shift = shifted;
        end
      end
      default: ;
    endcase

    // Record completion: payload is little-endian and sits at the top.
    fin_info = rec_decode(fin_tag);
    unique case (fin_tag[2:0])
      3'd2:    val = fin_shift;
      3'd1:    val = {32'd0, fin_shift[63:32]};
      default: val = '0;
    endcase
    if (fin) begin
      mode_d = MODE_TAG;
      unique case (fin_tag)
        TAG_END:    begin crc_d = val[31:0]; mode_d = MODE_TRAIL; end
        TAG_ID:     id_d = val[31:0];
        TAG_ADDR:   addr_d = val;
        TAG_MASK32: nmask_d = val[31:0];
        TAG_MASK64: wmask_d = val;
        default: begin
          act    = fin_info.is_action;
          addr_d = addr_q + {60'd0, fin_info.incr};
        end
      endcase
    end

    if (act) begin
      res_o.kind      = fin_info.kind;
      res_o.bus_id    = id_q;
      res_o.bus_addr  = addr_d;
      res_o.data_value = fin_info.zero_val ? 64'd0 :
                         fin_info.wide ? val : {32'd0, val[31:0]};
      res_o.data_mask = fin_info.wide ? wmask_q : {32'd0, nmask_q};
    end

    done = ({1'b0, pos_q} + 33'd1) >= {1'b0, len_cur};
    if (done) begin
      // The done item replaces any action finished by the last byte.
      res_o = '0;
      res_o.kind = KIND_BUF_DONE;
      res_o.status = (err_d != ST_OK) ? err_d :
                     (mode_d == MODE_TRAIL) ? ST_OK : ST_TRUNCATED;
      res_o.trailer_crc = crc_d;
      pos_d = '0; len_d = '0; tag_d = '0; left_d = '0; shift_d = '0;
      id_d = '0; addr_d = '0; nmask_d = '1; wmask_d = '1;
      mode_d = MODE_HEADER; err_d = ST_OK; crc_d = '0;
    end else begin
      pos_d = pos_q + 32'd1;
    end
    res_valid_o = done || act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; len_q <= '0; tag_q <= '0; left_q <= '0; shift_q <= '0;
      id_q <= '0; addr_q <= '0; nmask_q <= '1; wmask_q <= '1;
      mode_q <= MODE_HEADER; err_q <= ST_OK; crc_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d; len_q <= len_d; tag_q <= tag_d; left_q <= left_d;
      shift_q <= shift_d; id_q <= id_d; addr_q <= addr_d; nmask_q <= nmask_d;
      wmask_q <= wmask_d; mode_q <= mode_d; err_q <= err_d; crc_q <= crc_d;
    end
  end

endmodule

// ===== tb/bus_action_trace_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_action_trace_decoder_unit_test: self-checking bench for the decoder
// Streams replay buffers byte by byte into the decoder, mostly well-formed
// buffers with random records plus every kind of broken buffer, and checks
// each result item against a cycle-free decoder model kept in this bench.
// Both stream sides idle in random bursts except in the last part of the run.
// ----------------------------------------------------------------------------
module bus_action_trace_decoder_unit_test;
  import batd_pkg::*;

  // Record tags of the replay format.
  localparam logic [7:0] TAG_END           = 8'd1;
  localparam logic [7:0] TAG_START         = 8'd2;
  localparam logic [7:0] TAG_ID            = 8'd9;
  localparam logic [7:0] TAG_ADDR          = 8'd18;
  localparam logic [7:0] TAG_RD32          = 8'd25;
  localparam logic [7:0] TAG_RD64          = 8'd34;
  localparam logic [7:0] TAG_WR32          = 8'd41;
  localparam logic [7:0] TAG_WR64          = 8'd50;
  localparam logic [7:0] TAG_RD32_INC      = 8'd57;
  localparam logic [7:0] TAG_RD64_INC      = 8'd66;
  localparam logic [7:0] TAG_WR32_INC      = 8'd73;
  localparam logic [7:0] TAG_WR64_INC      = 8'd82;
  localparam logic [7:0] TAG_WR32_ZERO     = 8'd88;
  localparam logic [7:0] TAG_WR64_ZERO     = 8'd96;
  localparam logic [7:0] TAG_WR32_ZERO_INC = 8'd104;
  localparam logic [7:0] TAG_WR64_ZERO_INC = 8'd112;
  localparam logic [7:0] TAG_RDIGN32       = 8'd121;
  localparam logic [7:0] TAG_RDIGN64       = 8'd130;
  localparam logic [7:0] TAG_RDIGN32_INC   = 8'd137;
  localparam logic [7:0] TAG_RDIGN64_INC   = 8'd146;
  localparam logic [7:0] TAG_POLL32        = 8'd153;
  localparam logic [7:0] TAG_POLL64        = 8'd162;
  localparam logic [7:0] TAG_MASK32        = 8'd169;
  localparam logic [7:0] TAG_MASK64        = 8'd178;

  localparam logic [31:0] MAGIC_PLAIN  = 32'h0066424e;
  localparam logic [31:0] MAGIC_PACKED = 32'h007a424e;
  localparam logic [31:0] MIN_BUFFER   = 32'd14;

  // Buffer flavors drawn by the stimulus generator.
  localparam int FLAVOR_NO_END      = 62;
  localparam int FLAVOR_BAD_START   = 70;
  localparam int FLAVOR_BAD_MAGIC   = 74;
  localparam int FLAVOR_COMPRESSED  = 78;
  localparam int FLAVOR_LEN_SMALL   = 81;
  localparam int FLAVOR_UNKNOWN_TAG = 85;
  localparam int FLAVOR_TOO_SHORT   = 92;

  localparam int TAIL_ITEMS = 120;

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_TAG,
    MODE_PAYLOAD,
    MODE_TRAIL,
    MODE_SKIP
  } parse_mode_e;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [39:0]  s_tdata  = '0;
  logic         m_ready  = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [263:0] m_axis_tdata_o;
  logic [3:0]   m_axis_tuser_o;

  // Bytes waiting to be sent: [7:0] data_byte, [39:8] buffer_length.
  logic [39:0]  byte_feed[$];
  // Scratch buffer of the generator.
  logic [7:0]   frame[$];
  // Decoded items still to come from the block.
  batd_result_t pending_results[$];

  bit           failed      = 1'b0;
  logic         idle_phase  = 1'b1;
  logic         quiet_tail  = 1'b0;
  logic [6:0]   phase_count = '0;
  int unsigned  src_idle    = 0;
  int unsigned  snk_idle    = 0;
  wire          stall_ok    = idle_phase && !quiet_tail;

  // Decoder state mirrored by the bench.
  logic [31:0]  dec_pos;
  logic [31:0]  dec_len;
  logic [7:0]   dec_tag;
  logic [3:0]   dec_left;
  logic [63:0]  dec_shift;
  logic [31:0]  dec_id;
  logic [63:0]  dec_addr;
  logic [31:0]  dec_mask32;
  logic [63:0]  dec_mask64;
  parse_mode_e  dec_mode;
  status_e      dec_err;
  logic [31:0]  dec_crc;

  always #5 clk_i = ~clk_i;

  bus_action_trace_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_pos    = '0;
    dec_len    = '0;
    dec_tag    = '0;
    dec_left   = '0;
    dec_shift  = '0;
    dec_id     = '0;
    dec_addr   = '0;
    dec_mask32 = '1;
    dec_mask64 = '1;
    dec_mode   = MODE_HEADER;
    dec_err    = ST_OK;
    dec_crc    = '0;
  endfunction

  function automatic bit is_record_tag(logic [7:0] t);
    case (t)
      TAG_END, TAG_ID, TAG_ADDR, TAG_RD32, TAG_RD64, TAG_WR32, TAG_WR64,
      TAG_RD32_INC, TAG_RD64_INC, TAG_WR32_INC, TAG_WR64_INC, TAG_WR32_ZERO,
      TAG_WR64_ZERO, TAG_WR32_ZERO_INC, TAG_WR64_ZERO_INC, TAG_RDIGN32,
      TAG_RDIGN64, TAG_RDIGN32_INC, TAG_RDIGN64_INC, TAG_POLL32, TAG_POLL64,
      TAG_MASK32, TAG_MASK64: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void abort_buffer(status_e code);
    dec_err  = code;
    dec_mode = MODE_SKIP;
  endfunction

  function automatic batd_result_t bus_action(kind_e k, logic [63:0] v, bit wide);
    batd_result_t r;
    r             = '0;
    r.kind        = k;
    r.bus_id      = dec_id;
    r.bus_addr    = dec_addr;
    r.data_value  = wide ? v : {32'd0, v[31:0]};
    r.data_mask   = wide ? dec_mask64 : {32'd0, dec_mask32};
    r.status      = ST_OK;
    r.trailer_crc = '0;
    return r;
  endfunction

  // Applies a complete record; returns 1 when it makes a bus action.
  function automatic bit apply_record(output batd_result_t r);
    logic [63:0] v;
    bit          act;
    r   = '0;
    act = 1'b1;
    case (dec_tag[2:0])
      3'd2:    v = dec_shift;
      3'd1:    v = {32'd0, dec_shift[63:32]};
      default: v = '0;
    endcase
    dec_mode = MODE_TAG;
    case (dec_tag)
      TAG_END: begin
        dec_crc  = v[31:0];
        dec_mode = MODE_TRAIL;
        act      = 1'b0;
      end
      TAG_ID: begin
        dec_id = v[31:0];
        act    = 1'b0;
      end
      TAG_ADDR: begin
        dec_addr = v;
        act      = 1'b0;
      end
      TAG_MASK32: begin
        dec_mask32 = v[31:0];
        act        = 1'b0;
      end
      TAG_MASK64: begin
        dec_mask64 = v;
        act        = 1'b0;
      end
      TAG_RD32_INC: begin
        dec_addr += 64'd4;
        r = bus_action(KIND_RD32, v, 1'b0);
      end
      TAG_RD32: r = bus_action(KIND_RD32, v, 1'b0);
      TAG_RD64_INC: begin
        dec_addr += 64'd8;
        r = bus_action(KIND_RD64, v, 1'b1);
      end
      TAG_RD64: r = bus_action(KIND_RD64, v, 1'b1);
      TAG_POLL32: r = bus_action(KIND_POLL32, v, 1'b0);
      TAG_POLL64: r = bus_action(KIND_POLL64, v, 1'b1);
      TAG_RDIGN32_INC: begin
        dec_addr += 64'd4;
        r = bus_action(KIND_RDIGN32, v, 1'b0);
      end
      TAG_RDIGN32: r = bus_action(KIND_RDIGN32, v, 1'b0);
      TAG_RDIGN64_INC: begin
        dec_addr += 64'd8;
        r = bus_action(KIND_RDIGN64, v, 1'b1);
      end
      TAG_RDIGN64: r = bus_action(KIND_RDIGN64, v, 1'b1);
      TAG_WR32_INC: begin
        dec_addr += 64'd4;
        r = bus_action(KIND_WR32, v, 1'b0);
      end
      TAG_WR32: r = bus_action(KIND_WR32, v, 1'b0);
      TAG_WR32_ZERO_INC: begin
        dec_addr += 64'd4;
        r = bus_action(KIND_WR32, 64'd0, 1'b0);
      end
      TAG_WR32_ZERO: r = bus_action(KIND_WR32, 64'd0, 1'b0);
      TAG_WR64_INC: begin
        dec_addr += 64'd8;
        r = bus_action(KIND_WR64, v, 1'b1);
      end
      TAG_WR64: r = bus_action(KIND_WR64, v, 1'b1);
      TAG_WR64_ZERO_INC: begin
        dec_addr += 64'd8;
        r = bus_action(KIND_WR64, 64'd0, 1'b1);
      end
      TAG_WR64_ZERO: r = bus_action(KIND_WR64, 64'd0, 1'b1);
      default: act = 1'b0;
    endcase
    return act;
  endfunction

  // Runs one accepted byte through the model and queues what it yields.
  function automatic void decode_byte(logic [7:0] b, logic [31:0] blen);
    batd_result_t r;
    bit           act;
    act = 1'b0;
    r   = '0;
    if (dec_pos == 0) dec_len = blen;
    case (dec_mode)
      MODE_HEADER: begin
        if (dec_pos == 0) begin
          if (dec_len < MIN_BUFFER) abort_buffer(ST_TOO_SHORT);
          else if (b != TAG_START) abort_buffer(ST_BAD_START);
          dec_shift = '0;
        end else begin
          dec_shift = {b, dec_shift[63:8]};
          if (dec_pos == 4) begin
            if (dec_shift[63:32] == MAGIC_PACKED) abort_buffer(ST_COMPRESSED);
            else if (dec_shift[63:32] != MAGIC_PLAIN) abort_buffer(ST_BAD_MAGIC);
            dec_shift = '0;
          end else if (dec_pos == 8) begin
            if (dec_shift[63:32] < dec_len) abort_buffer(ST_LEN_SMALL);
            else dec_mode = MODE_TAG;
            dec_shift = '0;
          end
        end
      end
      MODE_TAG: begin
        if (!is_record_tag(b)) begin
          abort_buffer(ST_UNKNOWN_TAG);
        end else begin
          dec_tag   = b;
          dec_shift = '0;
          dec_left  = {b[1:0], 2'b00};
          if (b[2:0] == 3'd0) act = apply_record(r);
          else dec_mode = MODE_PAYLOAD;
        end
      end
      MODE_PAYLOAD: begin
        dec_shift = {b, dec_shift[63:8]};
        dec_left  = dec_left - 4'd1;
        if (dec_left == 0) act = apply_record(r);
      end
      default: ;
    endcase

    // The last byte of a buffer always yields the done item, which replaces
    // any action that the same byte completed.
    if ({1'b0, dec_pos} + 33'd1 >= {1'b0, dec_len}) begin
      r        = '0;
      r.kind   = KIND_BUF_DONE;
      if (dec_err != ST_OK) r.status = dec_err;
      else if (dec_mode == MODE_TRAIL) r.status = ST_OK;
      else r.status = ST_TRUNCATED;
      r.trailer_crc = dec_crc;
      pending_results.push_back(r);
      clear_decoder();
    end else begin
      dec_pos = dec_pos + 32'd1;
      if (act) pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void append_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) frame.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_record_tag();
    case ($urandom_range(0, 23))
      0, 1, 2: return TAG_ADDR;
      3:       return TAG_ID;
      4:       return TAG_MASK32;
      5:       return TAG_MASK64;
      6:       return TAG_RD32;
      7:       return TAG_RD64;
      8:       return TAG_WR32;
      9:       return TAG_WR64;
      10:      return TAG_RD32_INC;
      11:      return TAG_RD64_INC;
      12:      return TAG_WR32_INC;
      13:      return TAG_WR64_INC;
      14:      return TAG_WR32_ZERO;
      15:      return TAG_WR64_ZERO;
      16:      return TAG_WR32_ZERO_INC;
      17:      return TAG_WR64_ZERO_INC;
      18:      return TAG_RDIGN32;
      19:      return TAG_RDIGN64;
      20:      return TAG_RDIGN32_INC;
      21:      return TAG_RDIGN64_INC;
      22:      return TAG_POLL32;
      default: return TAG_POLL64;
    endcase
  endfunction

  function automatic void append_record(logic [7:0] t);
    logic [63:0] v;
    v = random_value();
    // Addresses near the top of the space make the increments wrap.
    if (t == TAG_ADDR && $urandom_range(0, 3) == 0)
      v = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
    frame.push_back(t);
    append_le(v, 4 * int'(t[2:0]));
  endfunction

  // Sends the frame as one buffer of len bytes (one byte if len is 0); the length
  // only counts on the first byte, so the other bytes carry random lengths.
  function automatic void queue_frame(int unsigned len);
    int unsigned count;
    logic [31:0] lf;
    logic [7:0]  b;
    count = (len == 0) ? 1 : len;
    for (int unsigned i = 0; i < count; i++) begin
      lf = (i == 0) ? len : $urandom;
      b  = (i < frame.size()) ? frame[i] : 8'($urandom_range(0, 255));
      byte_feed.push_back({lf, b});
    end
  endfunction

  function automatic void queue_buffer();
    int          flavor;
    int unsigned nrec;
    int unsigned bad_at;
    int unsigned len;
    logic [31:0] magic;
    logic [31:0] hdr_len;
    logic [7:0]  t;
    frame.delete();
    flavor = $urandom_range(0, 99);

    if (flavor >= FLAVOR_TOO_SHORT) begin
      frame.push_back(($urandom_range(0, 1) == 0) ? TAG_START : 8'($urandom));
      queue_frame($urandom_range(0, 13));
      return;
    end

    t = TAG_START;
    if (flavor >= FLAVOR_BAD_START && flavor < FLAVOR_BAD_MAGIC)
      while (t == TAG_START) t = 8'($urandom_range(0, 255));
    frame.push_back(t);

    magic = MAGIC_PLAIN;
    if (flavor >= FLAVOR_BAD_MAGIC && flavor < FLAVOR_COMPRESSED)
      while (magic == MAGIC_PLAIN || magic == MAGIC_PACKED)
        magic = ($urandom_range(0, 1) == 0) ? $urandom :
                (MAGIC_PLAIN ^ (32'd1 << $urandom_range(0, 31)));
    else if (flavor >= FLAVOR_COMPRESSED && flavor < FLAVOR_LEN_SMALL)
      magic = MAGIC_PACKED;
    append_le({32'd0, magic}, 4);
    append_le(64'd0, 4);  // length field, patched below

    nrec   = $urandom_range(0, 10);
    bad_at = (flavor >= FLAVOR_UNKNOWN_TAG && flavor < FLAVOR_TOO_SHORT) ?
             $urandom_range(0, nrec) : nrec + 1;
    for (int unsigned i = 0; i <= nrec; i++) begin
      if (i == bad_at) begin
        t = TAG_START;
        if ($urandom_range(0, 2) != 0)
          while (is_record_tag(t) || t == TAG_START) t = 8'($urandom_range(0, 255));
        frame.push_back(t);
      end
      if (i < nrec) append_record(pick_record_tag());
    end

    if (flavor >= FLAVOR_NO_END && flavor < FLAVOR_BAD_START) begin
      len = frame.size();
      if ($urandom_range(0, 1) == 0 && len > MIN_BUFFER)
        len = $urandom_range(MIN_BUFFER, len - 1);
    end else begin
      append_record(TAG_END);
      repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom_range(0, 255)));
      len = frame.size();
    end

    if (flavor >= FLAVOR_LEN_SMALL && flavor < FLAVOR_UNKNOWN_TAG)
      hdr_len = $urandom_range(0, len - 1);
    else
      case ($urandom_range(0, 3))
        0:       hdr_len = len;
        1:       hdr_len = len + $urandom_range(1, 1000);
        2:       hdr_len = '1;
        default: hdr_len = $urandom_range(len, 32'hFFFF_FFFF);
      endcase
    for (int i = 0; i < 4; i++) frame[5 + i] = hdr_len[8*i +: 8];

    queue_frame(len);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one byte item per handshake, idling in random bursts.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    phase_count <= phase_count + 7'd1;
    if (phase_count == 0) idle_phase <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      src_idle   <= 0;
      quiet_tail <= 1'b0;
      clear_decoder();
    end else begin
      if (s_tvalid && s_axis_tready_o) decode_byte(s_tdata[7:0], s_tdata[39:8]);
      // A held item stays on the bus until it is taken.
      if (!s_tvalid || s_axis_tready_o) begin
        if (src_idle > 0) begin
          src_idle <= src_idle - 1;
          s_tvalid <= 1'b0;
        end else if (byte_feed.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (stall_ok && $urandom_range(0, 9) == 0) begin
          src_idle <= $urandom_range(0, 17);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_feed.pop_front();
        end
      end
      quiet_tail <= (byte_feed.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Sink side: checks each result item against the oldest expectation.
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic check_result();
    batd_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with no expectation: kind %0d", m_axis_tuser_o);
      failed = 1'b1;
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind",        64'(want.kind),        64'(m_axis_tuser_o));
    compare_field("bus_id",      64'(want.bus_id),      64'(m_axis_tdata_o[31:0]));
    compare_field("bus_addr",    want.bus_addr,         m_axis_tdata_o[95:32]);
    compare_field("data_value",  want.data_value,       m_axis_tdata_o[159:96]);
    compare_field("data_mask",   want.data_mask,        m_axis_tdata_o[223:160]);
    compare_field("status",      64'(want.status),      64'(m_axis_tdata_o[226:224]));
    compare_field("trailer_crc", 64'(want.trailer_crc), 64'(m_axis_tdata_o[258:227]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      snk_idle <= 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) check_result();
      if (snk_idle > 0) begin
        snk_idle <= snk_idle - 1;
        m_ready  <= 1'b0;
      end else if (stall_ok && $urandom_range(0, 9) == 0) begin
        snk_idle <= $urandom_range(0, 17);
        m_ready  <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    // Directed opening: buffer lengths of zero and one end on the first byte,
    // a length of two is too short, then the smallest well-formed buffer with
    // all-ones length field and CRC word.
    frame.delete();
    frame.push_back(TAG_START);
    queue_frame(0);
    frame.delete();
    frame.push_back(8'hFF);
    queue_frame(1);
    frame.delete();
    frame.push_back(TAG_START);
    queue_frame(2);
    frame.delete();
    frame.push_back(TAG_START);
    append_le({32'd0, MAGIC_PLAIN}, 4);
    append_le(64'hFFFF_FFFF, 4);
    frame.push_back(TAG_END);
    append_le(64'hFFFF_FFFF, 4);
    queue_frame(MIN_BUFFER);

    while (byte_feed.size() < 900) queue_buffer();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0 || s_tvalid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
